// File: rtl/core/throttle_ramp_controller_defines.svh
// Assertion macros for the throttle ramp controller.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef THROTTLE_RAMP_CONTROLLER_DEFINES_SVH
`define THROTTLE_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/trc_pkg.sv
// Shared types and constants for the throttle ramp controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

    // Fixed point format of the motor speed and the near-zero band
    localparam int FRAC_BITS = 4;
    localparam int DEADBAND  = 5;

    // Field widths
    localparam int THR_W   = 9;
    localparam int SPEED_W = 13;
    localparam int STEP_W  = 12;
    localparam int LIMIT_W = 8;
    localparam int LEVEL_W = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]  ACCEL_STEP_RST  = 12'd16;
    localparam logic [STEP_W-1:0]  BRAKE_STEP_RST  = 12'd16;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 8'd255;

    // Register index, taken from paddr word address
    typedef enum logic [1:0] {
        REG_ACCEL_STEP  = 2'd0,
        REG_BRAKE_STEP  = 2'd1,
        REG_SPEED_LIMIT = 2'd2
    } reg_index_t;

    // Motor direction code
    typedef enum logic [1:0] {
        DIR_RELEASE  = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } drive_dir_t;

    // Configuration bundle from the register block to the datapath
    typedef struct packed {
        logic [STEP_W-1:0]  accel_step;
        logic [STEP_W-1:0]  brake_step;
        logic [LIMIT_W-1:0] speed_limit;
    } trc_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/trc_regs.sv
// APB-style configuration registers: accel step, brake step, speed limit.
// Depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_regs
    import trc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output trc_cfg_t               cfg
);

    logic [STEP_W-1:0]  accel_reg, accel_next;
    logic [STEP_W-1:0]  brake_reg, brake_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               wr_en;
    reg_index_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[3:2]);

    // Write decode
    always_comb
    begin
        accel_next = accel_reg;
        brake_next = brake_reg;
        limit_next = limit_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ACCEL_STEP:  accel_next = pwdata[STEP_W-1:0];
                REG_BRAKE_STEP:  brake_next = pwdata[STEP_W-1:0];
                REG_SPEED_LIMIT: limit_next = pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_STEP_RST;
            brake_reg <= BRAKE_STEP_RST;
            limit_reg <= SPEED_LIMIT_RST;
        end
        else
        begin
            accel_reg <= accel_next;
            brake_reg <= brake_next;
            limit_reg <= limit_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_ACCEL_STEP:  prdata = DATA_W'(accel_reg);
            REG_BRAKE_STEP:  prdata = DATA_W'(brake_reg);
            REG_SPEED_LIMIT: prdata = DATA_W'(limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.accel_step  = accel_reg;
    assign cfg.brake_step  = brake_reg;
    assign cfg.speed_limit = limit_reg;

endmodule

`default_nettype wire

// File: rtl/core/trc_clamp.sv
// Throttle clamp to +/- speed limit followed by the zero deadband.
// Depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_clamp
    import trc_pkg::*;
(
    input  wire logic signed [THR_W-1:0]   request,
    input  wire logic        [LIMIT_W-1:0] limit,
    output logic signed      [THR_W-1:0]   clamped
);

    localparam int CW = THR_W + 1;
    localparam logic signed [CW-1:0] DB_POS = CW'(DEADBAND);
    localparam logic signed [CW-1:0] DB_NEG = -CW'(DEADBAND);

    logic signed [CW-1:0] req_w;
    logic signed [CW-1:0] lim_pos;
    logic signed [CW-1:0] lim_neg;
    logic signed [CW-1:0] res_w;

    assign req_w   = CW'(request);
    assign lim_pos = signed'(CW'(limit));
    assign lim_neg = -lim_pos;

    // Clamp wins over the deadband
    always_comb
    begin
        priority if (req_w > lim_pos)
            res_w = lim_pos;
        else if (req_w < lim_neg)
            res_w = lim_neg;
        else if (req_w < DB_POS && req_w > DB_NEG)
            res_w = '0;
        else
            res_w = req_w;
    end

    assign clamped = res_w[THR_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/trc_ramp.sv
// Next motor speed: near-zero jump, accel/brake ramp, exact landing, e-brake.
// Depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_ramp
    import trc_pkg::*;
(
    input  wire logic signed [SPEED_W-1:0] speed,
    input  wire logic signed [THR_W-1:0]   target,
    input  wire logic                      ebrake,
    input  wire trc_cfg_t                  cfg,
    output logic signed      [SPEED_W-1:0] speed_new
);

    // One extra bit so the distance to the target never wraps
    localparam int RW = SPEED_W + 1;
    localparam logic signed [RW-1:0] ZONE_POS = RW'(DEADBAND << FRAC_BITS);
    localparam logic signed [RW-1:0] ZONE_NEG = -RW'(DEADBAND << FRAC_BITS);

    logic signed [RW-1:0] spd;
    logic signed [RW-1:0] tgt;
    logic signed [RW-1:0] acc;
    logic signed [RW-1:0] brk;
    logic signed [RW-1:0] diff;
    logic signed [RW-1:0] res;
    logic                 up;
    logic                 down;

    assign spd  = RW'(speed);
    assign tgt  = RW'(target) <<< FRAC_BITS;
    assign acc  = signed'(RW'(cfg.accel_step));
    assign brk  = signed'(RW'(cfg.brake_step));
    assign up   = tgt > spd;
    assign down = tgt < spd;
    assign diff = up ? (tgt - spd) : (spd - tgt);

    // Step selection; away from zero uses accel, toward zero uses brake
    always_comb
    begin
        priority if (ebrake)
            res = '0;
        else if (spd > ZONE_NEG && spd < ZONE_POS)
        begin
            priority if (tgt >= ZONE_POS)
                res = ZONE_POS;
            else if (tgt <= ZONE_NEG)
                res = ZONE_NEG;
            else
                res = '0;
        end
        else if (up && spd >= 0)
            res = (diff < acc) ? tgt : spd + acc;
        else if (down && spd > 0)
            res = (diff < brk) ? tgt : spd - brk;
        else if (down && spd <= 0)
            res = (diff < acc) ? tgt : spd - acc;
        else if (up && spd < 0)
            res = (diff < brk) ? tgt : spd + brk;
        else
            res = spd;
    end

    // Result lies between old speed and target, at a zone edge, or at zero
    assign speed_new = res[SPEED_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/throttle_ramp_controller.sv
// Throttle ramp controller: top level (slew-rate limited motor speed).
// Uses trc_pkg, trc_regs, trc_clamp, trc_ramp and the assertion macros.
//
// Input channel (in_valid/in_ready): one item per control tick, carrying
// throttle_request (signed whole units) and ebrake_on.
// Output channel (out_valid/out_ready): one result item per input item, in
// order: clamped_throttle, speed_now (Q4), drive_level, drive_dir, ebrake_active.
// Config: APB-style port, accel_step at 0x0, brake_step at 0x4, speed_limit
// at 0x8; pready is tied high, writes land on the access cycle.
// Pipeline: an accepted item is loaded into the input register, then into the
// result register, where out_valid rises; a held result register can delay it.
// Throughput: one item per cycle while the result register is free; the motor speed
// register is read and written once per item in the result stage, so ticks run back to back.
// Reset: speed returns to zero, registers to their defaults, both stages empty.
// Stall: while out_ready is low the result holds; one more item is taken into
// the input register, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "throttle_ramp_controller_defines.svh"

module throttle_ramp_controller
    import trc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // config port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic        [ADDR_W-1:0]  paddr,
    input  wire logic        [DATA_W-1:0]  pwdata,
    output logic             [DATA_W-1:0]  prdata,
    output logic                           pready,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [THR_W-1:0]   throttle_request,
    input  wire logic                      ebrake_on,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed      [THR_W-1:0]   clamped_throttle,
    output logic signed      [SPEED_W-1:0] speed_now,
    output logic             [LEVEL_W-1:0] drive_level,
    output logic             [1:0]         drive_dir,
    output logic                           ebrake_active
);

    trc_cfg_t cfg;

    // Input stage
    logic                      stg_valid_reg, stg_valid_next;
    logic signed [THR_W-1:0]   stg_clamped_reg;
    logic                      stg_ebrake_reg;
    logic signed [THR_W-1:0]   clamped_in;

    // Result stage and motor state
    logic                      out_valid_reg, out_valid_next;
    logic signed [THR_W-1:0]   clamped_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic        [LEVEL_W-1:0] level_reg;
    drive_dir_t                dir_reg;
    logic                      ebrake_reg;
    logic signed [SPEED_W-1:0] motor_speed_reg, motor_speed_next;

    logic                      advance;
    logic                      load_stg;
    logic                      load_out;
    logic signed [SPEED_W-1:0] speed_new;
    logic        [SPEED_W-1:0] mag;
    logic        [SPEED_W-1:0] mag_whole;
    logic        [LEVEL_W-1:0] level_new;
    drive_dir_t                dir_new;

    trc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trc_clamp u_clamp (
        .request (throttle_request),
        .limit   (cfg.speed_limit),
        .clamped (clamped_in)
    );

    trc_ramp u_ramp (
        .speed     (motor_speed_reg),
        .target    (stg_clamped_reg),
        .ebrake    (stg_ebrake_reg),
        .cfg       (cfg),
        .speed_new (speed_new)
    );

    // Handshake: result register frees when empty or taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !stg_valid_reg || advance;
    assign load_stg = in_valid && in_ready;
    assign load_out = stg_valid_reg && advance;

    always_comb
    begin
        stg_valid_next   = in_ready ? in_valid : stg_valid_reg;
        out_valid_next   = advance ? stg_valid_reg : out_valid_reg;
        motor_speed_next = load_out ? speed_new : motor_speed_reg;
    end

    // Drive level and direction from the new speed
    assign mag       = (speed_new < 0) ? SPEED_W'(-speed_new) : SPEED_W'(speed_new);
    assign mag_whole = mag >> FRAC_BITS;
    assign level_new = (|mag_whole[SPEED_W-1:LEVEL_W]) ? '1 : mag_whole[LEVEL_W-1:0];

    always_comb
    begin
        priority if (speed_new > 0)
            dir_new = DIR_FORWARD;
        else if (speed_new < 0)
            dir_new = DIR_BACKWARD;
        else
            dir_new = DIR_RELEASE;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            motor_speed_reg <= '0;
        end
        else
        begin
            stg_valid_reg   <= stg_valid_next;
            out_valid_reg   <= out_valid_next;
            motor_speed_reg <= motor_speed_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_stg)
        begin
            stg_clamped_reg <= clamped_in;
            stg_ebrake_reg  <= ebrake_on;
        end
        if (load_out)
        begin
            clamped_reg <= stg_clamped_reg;
            speed_reg   <= speed_new;
            level_reg   <= level_new;
            dir_reg     <= dir_new;
            ebrake_reg  <= stg_ebrake_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign clamped_throttle = clamped_reg;
    assign speed_now        = speed_reg;
    assign drive_level      = level_reg;
    assign drive_dir        = dir_reg;
    assign ebrake_active    = ebrake_reg;

    // Checks
    `TRC_ASSERT_SAME(a_ebrake_zero, out_valid_reg && ebrake_reg,
        speed_reg == '0 && dir_reg == DIR_RELEASE, "e-brake result with nonzero speed")
    `TRC_ASSERT_SAME(a_state_tracks_out, out_valid_reg, motor_speed_reg == speed_reg,
        "speed state differs from last result")
    `TRC_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, in_ready,
        "input stalled with empty result register")
    `TRC_ASSERT_NEXT(a_stage_moves, stg_valid_reg && advance, out_valid_reg,
        "item lost between stages")

endmodule

`default_nettype wire

// File: bench/tb_throttle_ramp_controller.sv
`timescale 1ns / 1ps
// Self-checking bench for throttle_ramp_controller: predicts every tick's result
// in a scoreboard class and compares all five result fields in order.
// Depends on trc_pkg and the throttle_ramp_controller RTL only.

module tb_throttle_ramp_controller;
    import trc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_DIRECTED = 16;

    // Directed ticks at reset settings: ramp out, e-brake, reverse, deadband edges
    localparam int DIRECTED_REQ [0:NUM_DIRECTED-1] =
        '{255, 255, 255, 200, -255, -255, 0, 0, 4, 5, 5, 6, -4, -5, -256, 0};
    localparam bit DIRECTED_BRK [0:NUM_DIRECTED-1] =
        '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};

    // One expected result item
    typedef struct {
        logic signed [THR_W-1:0]   clamped;
        logic signed [SPEED_W-1:0] speed;
        logic [LEVEL_W-1:0]        level;
        drive_dir_t                dir;
        logic                      ebrake;
    } tick_result_t;

    // Tracks the motor speed and settings, queues expected results, checks outputs
    class ramp_scoreboard;
        logic [STEP_W-1:0]  accel_q4;
        logic [STEP_W-1:0]  brake_q4;
        logic [LIMIT_W-1:0] limit;
        int                 speed_q4;
        tick_result_t       pending_ticks[$];
        int                 mismatches;
        int                 checked;
        int                 ebrake_ticks;
        int                 peak_speed;

        function new();
            accel_q4     = ACCEL_STEP_RST;
            brake_q4     = BRAKE_STEP_RST;
            limit        = SPEED_LIMIT_RST;
            speed_q4     = 0;
            mismatches   = 0;
            checked      = 0;
            ebrake_ticks = 0;
            peak_speed   = 0;
        endfunction

        function void write_register(reg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ACCEL_STEP:  accel_q4 = value[STEP_W-1:0];
                REG_BRAKE_STEP:  brake_q4 = value[STEP_W-1:0];
                REG_SPEED_LIMIT: limit    = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Limit clamp first, then the deadband on unclamped values
        function int clamp_request(int req);
            int lim;
            lim = int'(limit);
            if (req > lim)
                return lim;
            if (req < -lim)
                return -lim;
            if (req < DEADBAND && req > -DEADBAND)
                return 0;
            return req;
        endfunction

        // One ramp step of the Q4 speed toward the Q4 target
        function int ramp_speed(int spd, int tgt);
            int zone;
            int acc;
            int brk;
            int diff;
            zone = DEADBAND * (1 << FRAC_BITS);
            acc  = int'(accel_q4);
            brk  = int'(brake_q4);
            diff = (tgt > spd) ? tgt - spd : spd - tgt;
            // near-zero zone jumps straight out or to rest
            if (spd > -zone && spd < zone) begin
                if (tgt >= zone)
                    return zone;
                if (tgt <= -zone)
                    return -zone;
                return 0;
            end
            if (tgt > spd && spd >= 0)
                return (diff < acc) ? tgt : spd + acc;
            if (tgt < spd && spd > 0)
                return (diff < brk) ? tgt : spd - brk;
            if (tgt < spd && spd <= 0)
                return (diff < acc) ? tgt : spd - acc;
            if (tgt > spd && spd < 0)
                return (diff < brk) ? tgt : spd + brk;
            return spd;
        endfunction

        function void note_tick(logic signed [THR_W-1:0] req, logic brake);
            tick_result_t r;
            int           clamped;
            int           spd;
            int           mag;
            clamped = clamp_request(int'(req));
            spd     = brake ? 0 : ramp_speed(speed_q4, clamped * (1 << FRAC_BITS));
            speed_q4 = spd;
            mag = (spd < 0) ? -spd : spd;
            if (mag > peak_speed)
                peak_speed = mag;
            if (brake)
                ebrake_ticks++;
            r.clamped = THR_W'(clamped);
            r.speed   = SPEED_W'(spd);
            r.level   = ((mag >> FRAC_BITS) > (1 << LEVEL_W) - 1) ?
                        {LEVEL_W{1'b1}} : LEVEL_W'(mag >> FRAC_BITS);
            r.dir     = (spd > 0) ? DIR_FORWARD : ((spd < 0) ? DIR_BACKWARD : DIR_RELEASE);
            r.ebrake  = brake;
            pending_ticks.push_back(r);
        endfunction

        task report_error(string msg);
            if (mismatches < 40)
                $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic signed [THR_W-1:0] got_clamped,
                          logic signed [SPEED_W-1:0] got_speed,
                          logic [LEVEL_W-1:0] got_level,
                          logic [1:0] got_dir,
                          logic got_ebrake);
            tick_result_t want;
            if (pending_ticks.size() == 0) begin
                report_error("result item with no tick waiting for it");
                return;
            end
            want = pending_ticks.pop_front();
            if (got_clamped !== want.clamped)
                report_error($sformatf("result %0d clamped_throttle %0d, expected %0d",
                                       checked, got_clamped, want.clamped));
            if (got_speed !== want.speed)
                report_error($sformatf("result %0d speed_now %0d, expected %0d",
                                       checked, got_speed, want.speed));
            if (got_level !== want.level)
                report_error($sformatf("result %0d drive_level %0d, expected %0d",
                                       checked, got_level, want.level));
            if (got_dir !== want.dir)
                report_error($sformatf("result %0d drive_dir %0d, expected %0d",
                                       checked, got_dir, want.dir));
            if (got_ebrake !== want.ebrake)
                report_error($sformatf("result %0d ebrake_active %0b, expected %0b",
                                       checked, got_ebrake, want.ebrake));
            checked++;
        endtask
    endclass

    logic                      clk;
    logic                      rst_n            = 1'b0;
    logic                      psel             = 1'b0;
    logic                      penable          = 1'b0;
    logic                      pwrite           = 1'b0;
    logic        [ADDR_W-1:0]  paddr            = '0;
    logic        [DATA_W-1:0]  pwdata           = '0;
    logic        [DATA_W-1:0]  prdata;
    logic                      pready;
    logic                      in_valid         = 1'b0;
    logic                      in_ready;
    logic signed [THR_W-1:0]   throttle_request = '0;
    logic                      ebrake_on        = 1'b0;
    logic                      out_valid;
    logic                      out_ready        = 1'b0;
    logic signed [THR_W-1:0]   clamped_throttle;
    logic signed [SPEED_W-1:0] speed_now;
    logic        [LEVEL_W-1:0] drive_level;
    logic        [1:0]         drive_dir;
    logic                      ebrake_active;

    ramp_scoreboard sb = new();
    bit             steady_flow  = 1'b0;
    int             ticks_sent   = 0;
    int             settings_run = 0;
    int             idle_cycles  = 0;

    throttle_ramp_controller dut (.*);

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 30);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(clamped_throttle, speed_now, drive_level, drive_dir,
                            ebrake_active);
    end

    // Watchdog: no item moving on either side for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Present one tick, with a random gap before it, and wait for acceptance
    task automatic send_tick(input logic signed [THR_W-1:0] req, input logic brake);
        while (!steady_flow && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        throttle_request <= req;
        ebrake_on        <= brake;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(req, brake);
        ticks_sent++;
    endtask

    // Hold the input side until every expected result has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_ticks.size() != 0);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_register(idx, value);
    endtask

    task automatic configure(input logic [STEP_W-1:0] acc, input logic [STEP_W-1:0] brk,
                             input logic [LIMIT_W-1:0] lim);
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ACCEL_STEP, DATA_W'(acc));
        write_reg(REG_BRAKE_STEP, DATA_W'(brk));
        write_reg(REG_SPEED_LIMIT, DATA_W'(lim));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // Request mix: raw patterns, extremes, deadband edges, values within the limit
    function automatic logic signed [THR_W-1:0] pick_request();
        int lim;
        int pick;
        int v;
        lim  = int'(sb.limit);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            v = int'($urandom_range(0, (1 << THR_W) - 1)) - (1 << (THR_W - 1));
        else if (pick < 40) begin
            case ($urandom_range(0, 5))
                0:       v = 255;
                1:       v = -255;
                2:       v = -256;
                3:       v = lim;
                4:       v = -lim;
                default: v = (lim > 0) ? lim - 1 : 0;
            endcase
        end
        else if (pick < 60)
            v = int'($urandom_range(0, 2 * DEADBAND + 2)) - (DEADBAND + 1);
        else
            v = int'($urandom_range(0, 2 * lim)) - lim;
        return THR_W'(v);
    endfunction

    // Mostly held targets so the ramp plays out, plus brake pulses, dither and noise
    task automatic run_random(input int count);
        int                      left;
        int                      mode;
        int                      run_len;
        logic signed [THR_W-1:0] target;
        left = count;
        while (left > 0) begin
            mode = $urandom_range(0, 99);
            if (mode < 65) begin
                target  = pick_request();
                run_len = $urandom_range(1, 40);
                if (run_len > left)
                    run_len = left;
                repeat (run_len) begin
                    send_tick(target, $urandom_range(0, 99) < 2);
                    left--;
                end
            end
            else if (mode < 75) begin
                run_len = $urandom_range(1, 3);
                if (run_len > left)
                    run_len = left;
                repeat (run_len) begin
                    send_tick(pick_request(), 1'b1);
                    left--;
                end
            end
            else if (mode < 88) begin
                run_len = $urandom_range(2, 10);
                if (run_len > left)
                    run_len = left;
                repeat (run_len) begin
                    send_tick(THR_W'(int'($urandom_range(0, 12)) - 6), 1'b0);
                    left--;
                end
            end
            else begin
                send_tick(THR_W'($urandom_range(0, (1 << THR_W) - 1)),
                          1'($urandom_range(0, 1)));
                left--;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_tick(THR_W'(DIRECTED_REQ[i]), DIRECTED_BRK[i]);

        // directed: limit below the deadband, clamp wins
        configure(12'd40, 12'd24, 8'd3);
        send_tick(9'sd255, 1'b0);
        send_tick(-9'sd4, 1'b0);
        send_tick(9'sd3, 1'b0);
        send_tick(9'h100, 1'b0);

        // directed: full steps land exactly on the target
        configure(12'd4080, 12'd4080, 8'd255);
        send_tick(9'sd255, 1'b0);
        send_tick(9'sd255, 1'b0);
        send_tick(9'sd100, 1'b0);
        send_tick(-9'sd100, 1'b0);

        // directed: zero steps hold the speed, zero limit clamps all to zero
        configure(12'd0, 12'd0, 8'd0);
        send_tick(9'sd0, 1'b0);
        send_tick(9'sd255, 1'b0);
        send_tick(9'h100, 1'b0);
        send_tick(9'sd9, 1'b0);

        // random: no idling on either side
        steady_flow = 1'b1;
        configure(12'd4080, 12'd4080, 8'd255);
        run_random(90);
        steady_flow = 1'b0;

        configure(12'd1, 12'd1, 8'd255);
        run_random(80);
        configure(12'd0, 12'd37, 8'd100);
        run_random(80);
        configure(12'd200, 12'd0, 8'd3);
        run_random(60);

        // pause mid-stream until the pipeline is empty
        configure(12'd16, 12'd16, 8'd255);
        run_random(40);
        wait_results_done();
        run_random(40);

        configure(12'd4080, 12'd1, 8'd255);
        run_random(80);
        configure(12'd1, 12'd4080, 8'd50);
        run_random(80);
        configure(12'd123, 12'd77, 8'd0);
        run_random(30);

        repeat (4) begin
            configure(($urandom_range(0, 1) != 0) ? STEP_W'($urandom_range(1, 64))
                                                  : STEP_W'($urandom_range(1, 4080)),
                      ($urandom_range(0, 1) != 0) ? STEP_W'($urandom_range(1, 64))
                                                  : STEP_W'($urandom_range(1, 4080)),
                      LIMIT_W'($urandom_range(1, 255)));
            run_random(70);
        end

        // drain and let any stray result show up
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_ticks.size() != 0)
            sb.report_error($sformatf("%0d expected results never arrived",
                                      sb.pending_ticks.size()));

        $display("Ran %0d ticks under %0d register settings, %0d with the emergency brake.",
                 ticks_sent, settings_run + 1, sb.ebrake_ticks);
        $display("Checked %0d results; largest speed magnitude %0d (Q4).",
                 sb.checked, sb.peak_speed);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
